@@ sv/prpu_pkg.sv @@
// Package with the shared types, codes and constants of the point rotate and project unit.
`timescale 1ns / 1ps
`default_nettype none
package prpu_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 15;
    localparam int DIV_Q_BITS = 25;
    localparam int FIRST_DIV = 3;
    localparam int NSTAGE = FIRST_DIV + DIV_Q_BITS + 1;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic [14:0] FOCAL_RESET = 15'd20480;
    localparam logic [9:0] SCALE_RESET = 10'd100;
    localparam logic [10:0] CX_RESET = 11'd400;
    localparam logic [10:0] CY_RESET = 11'd300;

    localparam logic signed [26:0] OUT_MAX = 27'sd8388607;
    localparam logic signed [26:0] OUT_MIN = -27'sd8388608;

    typedef enum logic [1:0] {
        FN_ROT_Y = 2'd0,
        FN_ROT_X = 2'd1,
        FN_PROJ = 2'd2,
        FN_PASS = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_SAT = 2'd1,
        ST_DEPTH = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOCAL = 2'd0,
        REG_SCALE = 2'd1,
        REG_CX = 2'd2,
        REG_CY = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [24:0] k;
        logic [10:0] cx;
        logic [10:0] cy;
    } t_cfg;

    typedef struct packed {
        t_func func;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] pz;
        logic [1:0] quad;
        logic [15:0] t;
        logic signed [16:0] d;
    } t_item;

    typedef struct packed {
        t_func func;
        logic bad;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] pz;
        logic [16:0] us;
        logic [16:0] uc;
        logic sneg;
        logic cneg;
        logic [16:0] u2s;
        logic [16:0] u2c;
        logic [15:0] i2s;
        logic [15:0] i2c;
        logic [16:0] pls;
        logic [16:0] plc;
        logic signed [15:0] sn;
        logic signed [15:0] cs;
        logic signed [31:0] m0;
        logic signed [31:0] m1;
        logic signed [31:0] m2;
        logic signed [31:0] m3;
        logic signed [23:0] ra;
        logic signed [23:0] rz;
        logic signed [40:0] prx;
        logic signed [40:0] pry;
        logic negx;
        logic negy;
        logic [42:0] nx;
        logic [42:0] ny;
        logic [16:0] dd;
        logic [16:0] remx;
        logic [16:0] remy;
        logic [24:0] qx;
        logic [24:0] qy;
        logic ovx;
        logic ovy;
        logic signed [23:0] ox;
        logic signed [23:0] oy;
        logic signed [23:0] oz;
        t_status st;
    } t_work;

endpackage
`default_nettype wire

@@ sv/prpu_in_if.sv @@
// Request channel interface carrying one input point.
`timescale 1ns / 1ps
`default_nettype none
interface prpu_in_if;
    logic valid;
    logic ready;
    logic [1:0] func;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
    logic [15:0] angle;

    modport source (output valid, func, point_x, point_y, point_z, angle, input ready);
    modport sink (input valid, func, point_x, point_y, point_z, angle, output ready);
endinterface
`default_nettype wire

@@ sv/prpu_out_if.sv @@
// Result channel interface carrying one transformed point.
`timescale 1ns / 1ps
`default_nettype none
interface prpu_out_if;
    logic valid;
    logic ready;
    logic signed [23:0] out_x;
    logic signed [23:0] out_y;
    logic signed [23:0] out_z;
    logic [1:0] status;

    modport source (output valid, out_x, out_y, out_z, status, input ready);
    modport sink (input valid, out_x, out_y, out_z, status, output ready);
endinterface
`default_nettype wire

@@ sv/prpu_front.sv @@
// Front stage: configuration registers, request intake and classification.
`timescale 1ns / 1ps
`default_nettype none
module prpu_front (
    input wire logic i_clk,
    input wire logic i_rst_n,
    prpu_in_if.sink i_in,
    input wire logic i_cfg_we,
    input wire logic [prpu_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input wire logic [prpu_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input wire logic i_q_full,
    output prpu_pkg::t_item o_item,
    output logic o_push,
    output prpu_pkg::t_cfg o_cfg
);
    import prpu_pkg::*;

    logic [14:0] r_focal;
    logic [9:0] r_scale;
    logic [10:0] r_cx;
    logic [10:0] r_cy;
    logic [24:0] r_k;
    logic r_valid;
    t_item r_item;
    t_item n_item;
    logic [15+ANGLE_BITS:0] phase_w;
    logic [ANGLE_BITS-1:0] phase;
    logic [ANGLE_BITS+15:0] frac_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal <= FOCAL_RESET;
            r_scale <= SCALE_RESET;
            r_cx <= CX_RESET;
            r_cy <= CY_RESET;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_FOCAL: r_focal <= i_cfg_data;
                REG_SCALE: r_scale <= i_cfg_data[9:0];
                REG_CX: r_cx <= i_cfg_data[10:0];
                REG_CY: r_cy <= i_cfg_data[10:0];
                default: r_cy <= r_cy;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_k <= 25'(r_focal) * 25'(r_scale);
    end

    assign i_in.ready = !r_valid || !i_q_full;

    always_comb begin
        phase_w = {i_in.angle, {ANGLE_BITS{1'b0}}};
        phase = phase_w[15+ANGLE_BITS:16];
        frac_w = {phase[ANGLE_BITS-3:0], 18'b0};
        n_item.func = t_func'(i_in.func);
        n_item.px = i_in.point_x;
        n_item.py = i_in.point_y;
        n_item.pz = i_in.point_z;
        n_item.quad = phase[ANGLE_BITS-1:ANGLE_BITS-2];
        n_item.t = 16'(frac_w >> ANGLE_BITS);
        n_item.d = $signed({2'b0, r_focal}) + 17'(i_in.point_z);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;
    assign o_push = r_valid && !i_q_full;
    assign o_cfg = '{k: r_k, cx: r_cx, cy: r_cy};
endmodule
`default_nettype wire

@@ sv/prpu_queue.sv @@
// Short queue between the front stage and the arithmetic pipeline.
`timescale 1ns / 1ps
`default_nettype none
module prpu_queue (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_push,
    input prpu_pkg::t_item i_item,
    output logic o_full,
    input wire logic i_pop,
    output logic o_valid,
    output prpu_pkg::t_item o_item
);
    import prpu_pkg::*;

    t_item r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0] r_cnt;
    logic do_pop;

    assign o_full = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign do_pop = i_pop && o_valid;
    assign o_item = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (QPTR_W+1)'(i_push) - (QPTR_W+1)'(do_pop);
        end
    end
endmodule
`default_nettype wire

@@ sv/prpu_back.sv @@
// Arithmetic pipeline: sine and cosine, rotation, pipelined division and result selection.
`timescale 1ns / 1ps
`default_nettype none
module prpu_back (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_valid,
    input prpu_pkg::t_item i_item,
    input prpu_pkg::t_cfg i_cfg,
    output logic o_pop,
    prpu_out_if.source o_out
);
    import prpu_pkg::*;

    localparam int LAST = NSTAGE - 1;

    t_work r_pipe [NSTAGE];
    t_work n_pipe [NSTAGE];
    logic [NSTAGE-1:0] r_vld;
    logic en;

    logic [33:0] m_a;
    logic [33:0] m_b;
    logic [33:0] m_c;
    logic [33:0] m_d;
    logic [40:0] mag_x;
    logic [40:0] mag_y;
    logic [17:0] r_sn;
    logic [17:0] r_cs;
    logic [14:0] cl_sn;
    logic [14:0] cl_cs;
    logic signed [15:0] rot_a;
    logic signed [32:0] sum_a;
    logic signed [32:0] sum_z;
    logic [17:0] tr_x;
    logic [17:0] tr_y;
    logic signed [26:0] qv_x;
    logic signed [26:0] qv_y;
    logic signed [26:0] sm_x;
    logic signed [26:0] sm_y;
    logic signed [23:0] sat_x;
    logic signed [23:0] sat_y;
    logic hit;
    t_work f;

    assign en = !r_vld[LAST] || o_out.ready;
    assign o_pop = en;

    always_comb begin
        for (int i = 1; i < NSTAGE; i++) begin
            n_pipe[i] = r_pipe[i-1];
        end

        n_pipe[0] = r_pipe[0];
        n_pipe[0].func = i_item.func;
        n_pipe[0].px = i_item.px;
        n_pipe[0].py = i_item.py;
        n_pipe[0].pz = i_item.pz;
        n_pipe[0].bad = (i_item.d <= 0);
        n_pipe[0].us = i_item.quad[0] ? 17'(17'h10000 - i_item.t) : {1'b0, i_item.t};
        n_pipe[0].uc = i_item.quad[0] ? {1'b0, i_item.t} : 17'(17'h10000 - i_item.t);
        n_pipe[0].sneg = i_item.quad[1];
        n_pipe[0].cneg = i_item.quad[1] ^ i_item.quad[0];
        n_pipe[0].prx = $signed({{25{i_item.px[15]}}, i_item.px}) * $signed({16'b0, i_cfg.k});
        n_pipe[0].pry = $signed({{25{i_item.py[15]}}, i_item.py}) * $signed({16'b0, i_cfg.k});
        n_pipe[0].dd = {i_item.d[15:0], 1'b0};

        m_a = 34'(r_pipe[0].us) * 34'(r_pipe[0].us);
        m_b = 34'(r_pipe[0].uc) * 34'(r_pipe[0].uc);
        n_pipe[1].u2s = 17'(m_a >> 16);
        n_pipe[1].u2c = 17'(m_b >> 16);
        n_pipe[1].negx = r_pipe[0].prx[40];
        n_pipe[1].negy = r_pipe[0].pry[40];
        mag_x = r_pipe[0].prx[40] ? 41'(-r_pipe[0].prx) : r_pipe[0].prx;
        mag_y = r_pipe[0].pry[40] ? 41'(-r_pipe[0].pry) : r_pipe[0].pry;
        n_pipe[1].nx = {1'b0, mag_x, 1'b0} + 43'(r_pipe[0].dd >> 1);
        n_pipe[1].ny = {1'b0, mag_y, 1'b0} + 43'(r_pipe[0].dd >> 1);

        m_c = 34'(r_pipe[1].u2s) * 34'd4640;
        m_d = 34'(r_pipe[1].u2c) * 34'd4640;
        n_pipe[2].i2s = 16'(16'd42047 - 16'(m_c >> 16));
        n_pipe[2].i2c = 16'(16'd42047 - 16'(m_d >> 16));
        n_pipe[2].ovx = (r_pipe[1].nx[42:25] >= {1'b0, r_pipe[1].dd});
        n_pipe[2].ovy = (r_pipe[1].ny[42:25] >= {1'b0, r_pipe[1].dd});
        n_pipe[2].remx = r_pipe[1].nx[41:25];
        n_pipe[2].remy = r_pipe[1].ny[41:25];
        n_pipe[2].qx = '0;
        n_pipe[2].qy = '0;

        n_pipe[3].pls = 17'(17'd102944 - 17'((34'(r_pipe[2].u2s) * 34'(r_pipe[2].i2s)) >> 16));
        n_pipe[3].plc = 17'(17'd102944 - 17'((34'(r_pipe[2].u2c) * 34'(r_pipe[2].i2c)) >> 16));

        r_sn = 18'((18'((34'(r_pipe[3].us) * 34'(r_pipe[3].pls)) >> 16) + 18'd2) >> 2);
        r_cs = 18'((18'((34'(r_pipe[3].uc) * 34'(r_pipe[3].plc)) >> 16) + 18'd2) >> 2);
        cl_sn = (r_sn > 18'd16384) ? 15'd16384 : r_sn[14:0];
        cl_cs = (r_cs > 18'd16384) ? 15'd16384 : r_cs[14:0];
        n_pipe[4].sn = r_pipe[3].sneg ? -$signed({1'b0, cl_sn}) : $signed({1'b0, cl_sn});
        n_pipe[4].cs = r_pipe[3].cneg ? -$signed({1'b0, cl_cs}) : $signed({1'b0, cl_cs});

        rot_a = (r_pipe[4].func == FN_ROT_Y) ? r_pipe[4].px : r_pipe[4].py;
        n_pipe[5].m0 = r_pipe[4].cs * rot_a;
        n_pipe[5].m1 = r_pipe[4].sn * r_pipe[4].pz;
        n_pipe[5].m2 = r_pipe[4].sn * rot_a;
        n_pipe[5].m3 = r_pipe[4].cs * r_pipe[4].pz;

        sum_a = 33'(r_pipe[5].m0) - 33'(r_pipe[5].m1) + 33'sd8192;
        sum_z = 33'(r_pipe[5].m2) + 33'(r_pipe[5].m3) + 33'sd8192;
        n_pipe[6].ra = 24'(sum_a >>> 14);
        n_pipe[6].rz = 24'(sum_z >>> 14);

        for (int j = FIRST_DIV; j < FIRST_DIV + DIV_Q_BITS; j++) begin
            tr_x = {r_pipe[j-1].remx, r_pipe[j-1].nx[FIRST_DIV + DIV_Q_BITS - 1 - j]};
            tr_y = {r_pipe[j-1].remy, r_pipe[j-1].ny[FIRST_DIV + DIV_Q_BITS - 1 - j]};
            if (tr_x >= {1'b0, r_pipe[j-1].dd}) begin
                n_pipe[j].remx = 17'(tr_x - {1'b0, r_pipe[j-1].dd});
                n_pipe[j].qx[FIRST_DIV + DIV_Q_BITS - 1 - j] = 1'b1;
            end else begin
                n_pipe[j].remx = tr_x[16:0];
            end
            if (tr_y >= {1'b0, r_pipe[j-1].dd}) begin
                n_pipe[j].remy = 17'(tr_y - {1'b0, r_pipe[j-1].dd});
                n_pipe[j].qy[FIRST_DIV + DIV_Q_BITS - 1 - j] = 1'b1;
            end else begin
                n_pipe[j].remy = tr_y[16:0];
            end
        end

        f = r_pipe[LAST-1];
        qv_x = f.ovx ? 27'sd33554432 : $signed({2'b0, f.qx});
        qv_y = f.ovy ? 27'sd33554432 : $signed({2'b0, f.qy});
        if (f.negx) begin
            qv_x = -qv_x;
        end
        if (f.negy) begin
            qv_y = -qv_y;
        end
        sm_x = $signed({4'b0, i_cfg.cx, 12'b0}) + qv_x;
        sm_y = $signed({4'b0, i_cfg.cy, 12'b0}) + qv_y;
        hit = 1'b0;
        if (sm_x > OUT_MAX) begin
            sat_x = 24'(OUT_MAX);
            hit = 1'b1;
        end else if (sm_x < OUT_MIN) begin
            sat_x = 24'(OUT_MIN);
            hit = 1'b1;
        end else begin
            sat_x = 24'(sm_x);
        end
        if (sm_y > OUT_MAX) begin
            sat_y = 24'(OUT_MAX);
            hit = 1'b1;
        end else if (sm_y < OUT_MIN) begin
            sat_y = 24'(OUT_MIN);
            hit = 1'b1;
        end else begin
            sat_y = 24'(sm_y);
        end

        n_pipe[LAST].ox = 24'(f.px);
        n_pipe[LAST].oy = 24'(f.py);
        n_pipe[LAST].oz = 24'(f.pz);
        n_pipe[LAST].st = ST_OK;
        case (f.func)
            FN_ROT_Y: begin
                n_pipe[LAST].ox = f.ra;
                n_pipe[LAST].oz = f.rz;
            end
            FN_ROT_X: begin
                n_pipe[LAST].oy = f.ra;
                n_pipe[LAST].oz = f.rz;
            end
            FN_PROJ: begin
                n_pipe[LAST].oz = '0;
                if (f.bad) begin
                    n_pipe[LAST].ox = '0;
                    n_pipe[LAST].oy = '0;
                    n_pipe[LAST].st = ST_DEPTH;
                end else begin
                    n_pipe[LAST].ox = sat_x;
                    n_pipe[LAST].oy = sat_y;
                    n_pipe[LAST].st = hit ? ST_SAT : ST_OK;
                end
            end
            default: begin
                n_pipe[LAST].st = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTAGE-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < NSTAGE; i++) begin
                r_pipe[i] <= n_pipe[i];
            end
        end
    end

    assign o_out.valid = r_vld[LAST];
    assign o_out.out_x = r_pipe[LAST].ox;
    assign o_out.out_y = r_pipe[LAST].oy;
    assign o_out.out_z = r_pipe[LAST].oz;
    assign o_out.status = r_pipe[LAST].st;

    a_depth_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[LAST] && r_pipe[LAST].st == ST_DEPTH |->
            r_pipe[LAST].ox == '0 && r_pipe[LAST].oy == '0 && r_pipe[LAST].oz == '0)
        else $error("depth fault result is not zero");

    a_rot_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[LAST] && r_pipe[LAST].func != FN_PROJ |-> r_pipe[LAST].st == ST_OK)
        else $error("non-projection request flagged");

    a_proj_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[LAST] && r_pipe[LAST].func == FN_PROJ |-> r_pipe[LAST].oz == '0)
        else $error("projection z is not zero");
endmodule
`default_nettype wire

@@ sv/point_rotate_project_unit.sv @@
// Top level of the point rotate and project unit.
//
// One request on i_in carries a func select, a Q4.12 point and a 16-bit angle.
// Func 0 rotates about Y, func 1 about X, func 2 projects to the screen and
// func 3 passes the point through. Each request gives exactly one result on
// o_out with Q12.12 coordinates and a status code.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data while
// no request is in flight: focal length, pixel scale and the screen center.
// A request goes through an intake register, a four-entry queue and a
// 29-stage arithmetic pipeline. The pipeline length is set by the
// projection divider, which retires one quotient bit per stage.
// One request is taken and one result delivered every cycle in steady state.
// With a result waiting and o_out.ready low the pipeline holds; the queue
// and intake register take requests until they fill, then i_in.ready drops.
// Synchronous reset empties the queue and pipeline and restores the default
// configuration registers.
`timescale 1ns / 1ps
`default_nettype none
module point_rotate_project_unit (
    input wire logic i_clk,
    input wire logic i_rst_n,
    prpu_in_if.sink i_in,
    prpu_out_if.source o_out,
    input wire logic i_cfg_we,
    input wire logic [prpu_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input wire logic [prpu_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import prpu_pkg::*;

    t_item front_item;
    t_item head_item;
    t_cfg cfg;
    logic push;
    logic q_full;
    logic q_valid;
    logic pop;

    prpu_front u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(i_in),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_q_full(q_full),
        .o_item(front_item),
        .o_push(push),
        .o_cfg(cfg)
    );

    prpu_queue u_queue (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(push),
        .i_item(front_item),
        .o_full(q_full),
        .i_pop(pop),
        .o_valid(q_valid),
        .o_item(head_item)
    );

    prpu_back u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(q_valid),
        .i_item(head_item),
        .i_cfg(cfg),
        .o_pop(pop),
        .o_out(o_out)
    );
endmodule
`default_nettype wire
